// ===== rtl/mrfpg_pkg.sv =====
// Package for the MRF prior gradient core: sizes, codes, weights and the
// interface structs shared by the line buffer, the divider and the top level.
// No dependencies.
package mrfpg_pkg;

   localparam int PIXEL_BITS  = 16;
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int POS_W       = 10;           // counter / position width
   localparam int DIM_W       = 11;           // size register width
   localparam int LB_ADDR_W   = $clog2(MAX_COLUMNS);
   localparam int LB_DATA_W   = 2 * PIXEL_BITS;

   // shared divider sizes: quotient always fits in 48 bits
   localparam int DIV_NUM_W = 81;
   localparam int DIV_DEN_W = 49;
   localparam int DIV_Q_W   = 48;
   localparam int DIV_CNT_W = 6;

   // neighbour weights, Q0.16
   localparam logic [14:0] W4_ONLY  = 15'd16384;
   localparam logic [14:0] W4_MIXED = 15'd9598;
   localparam logic [14:0] W8_MIXED = 15'd6786;

   // register indexes
   localparam logic [2:0] CSR_COLUMNS   = 3'd0;
   localparam logic [2:0] CSR_ROWS      = 3'd1;
   localparam logic [2:0] CSR_DELTA     = 3'd2;
   localparam logic [2:0] CSR_EIGHT     = 3'd3;
   localparam logic [2:0] CSR_POTENTIAL = 3'd4;

   // clique functions; the unknown code contributes nothing
   localparam logic [1:0] POT_QUAD    = 2'd0;
   localparam logic [1:0] POT_HUBER   = 2'd1;
   localparam logic [1:0] POT_GEMAN   = 2'd2;
   localparam logic [1:0] POT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic                 rd_en;
      logic [LB_ADDR_W-1:0] rd_addr;
      logic                 wr_en;
      logic [LB_ADDR_W-1:0] wr_addr;
      logic [LB_DATA_W-1:0] wr_data;
   } lbuf_req_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/mrfpg_line_mem.sv =====
// Line buffer memory: both previous rows of one column share a word.
// Clears itself after reset. Depends on mrfpg_pkg.
module mrfpg_line_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  mrfpg_pkg::lbuf_req_type         lb_req,
   output logic [mrfpg_pkg::LB_DATA_W-1:0] rd_data,
   output logic                            ready
);

   logic [mrfpg_pkg::LB_DATA_W-1:0] mem [mrfpg_pkg::MAX_COLUMNS];
   logic [mrfpg_pkg::LB_ADDR_W:0]   clr_cnt_ff, clr_cnt_in;
   logic [mrfpg_pkg::LB_DATA_W-1:0] rd_data_ff;

   assign ready   = clr_cnt_ff[mrfpg_pkg::LB_ADDR_W];
   assign rd_data = rd_data_ff;

   // clearing sweep counter
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (!ready) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (!ready) begin
         mem[clr_cnt_ff[mrfpg_pkg::LB_ADDR_W-1:0]] <= '0;
      end else if (lb_req.wr_en) begin
         mem[lb_req.wr_addr] <= lb_req.wr_data;
      end
      if (lb_req.rd_en) begin
         rd_data_ff <= mem[lb_req.rd_addr];
      end
   end

endmodule

// ===== rtl/mrfpg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 48 quotient bits.
// The caller guarantees the quotient fits. Depends on mrfpg_pkg.
module mrfpg_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  mrfpg_pkg::div_req_type div_req,
   output mrfpg_pkg::div_rsp_type div_rsp
);

   logic [mrfpg_pkg::DIV_DEN_W:0]   rem_ff, rem_in;
   logic [mrfpg_pkg::DIV_Q_W-1:0]   num_ff, num_in;
   logic [mrfpg_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [mrfpg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mrfpg_pkg::DIV_DEN_W:0]   trial;
   logic                            fits;

   assign trial = {rem_ff[mrfpg_pkg::DIV_DEN_W-1:0], num_ff[mrfpg_pkg::DIV_Q_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = {{(mrfpg_pkg::DIV_DEN_W + 1 + mrfpg_pkg::DIV_Q_W
                      - mrfpg_pkg::DIV_NUM_W){1'b0}},
                    div_req.num[mrfpg_pkg::DIV_NUM_W-1:mrfpg_pkg::DIV_Q_W]};
         num_in  = div_req.num[mrfpg_pkg::DIV_Q_W-1:0];
         den_in  = div_req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one numerator bit, quotient bit fills from the right
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         num_in = {num_ff[mrfpg_pkg::DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mrfpg_pkg::DIV_CNT_W'(mrfpg_pkg::DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

// ===== rtl/mrf_prior_gradient_core.sv =====
// MRF prior gradient core. A pixel with no result only passes the line buffer
// and the window. For an interior pixel (T = 4 or 8 terms) the curvature 2^32/D
// and each nonzero term run one division (Geman two) on the shared
// divider; a zero difference or unknown potential term skips the divider.
// The result waits in a register until it is taken.
// After reset the line buffer is cleared with req_stall high.
// Depends on mrfpg_pkg, mrfpg_line_mem and mrfpg_divider.
module mrf_prior_gradient_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_pixel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_gradient,
   output logic [9:0]          rsp_centre_row,
   output logic [9:0]          rsp_centre_col,
   output logic [31:0]         rsp_curvature,
   output logic                rsp_last
);

   localparam int PB = mrfpg_pkg::PIXEL_BITS;
   localparam int PW = mrfpg_pkg::POS_W;
   localparam int DW = mrfpg_pkg::DIM_W;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_WIN   = 9'b000000010,
      ST_CURV  = 9'b000000100,
      ST_LOAD  = 9'b000001000,
      ST_MUL1  = 9'b000010000,
      ST_MUL2  = 9'b000100000,
      ST_START = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [DW-1:0] cols_ff, rows_ff;
   logic [15:0]   dq_ff;
   logic          eight_ff;
   logic [1:0]    pot_ff;

   // position and window
   logic [PW-1:0] col_ff, col_in, row_ff, row_in;
   logic [PB-1:0] win_ff [9];
   logic [PB-1:0] win_in [9];
   logic [PB-1:0] px_ff, px_in;
   logic [PW-1:0] wcol_ff, wcol_in;
   logic          par_ff, par_in;
   logic          emit_ff, emit_in;
   logic          last_ff, last_in;
   logic [PW-1:0] orow_ff, orow_in, ocol_ff, ocol_in;

   // term arithmetic
   logic [15:0]   dqe_ff, dqe_in;
   logic [31:0]   dd_ff, dd_in;
   logic [31:0]   curv_ff, curv_in;
   logic [3:0]    k_ff, k_in;
   logic [PB-1:0] a_ff, a_in;
   logic          neg_ff, neg_in;
   logic [14:0]   w_ff, w_in;
   logic [30:0]   wa_ff, wa_in;
   logic [31:0]   aa_ff, aa_in;
   logic [61:0]   wad_ff, wad_in;
   logic [48:0]   s_ff, s_in;
   logic          phase_ff, phase_in;
   logic signed [51:0] sum_ff, sum_in;

   // response register
   logic               rv_ff, rv_in;
   logic signed [31:0] rgrad_ff, rgrad_in;
   logic [PW-1:0]      rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [31:0]        rcurv_ff, rcurv_in;
   logic               rlast_ff, rlast_in;

   mrfpg_pkg::lbuf_req_type lb_req;
   mrfpg_pkg::div_req_type  div_req;
   mrfpg_pkg::div_rsp_type  div_rsp;
   logic [mrfpg_pkg::LB_DATA_W-1:0] lb_rd;
   logic                            lb_ready;

   logic [DW-1:0] cols_eff, rows_eff;
   logic [DW-1:0] col_nx, row_nx;
   logic          accept;
   logic [PB-1:0] nb, above2, above1;
   logic          huber_quad;
   logic signed [51:0] term;

   mrfpg_line_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .lb_req  (lb_req),
      .rd_data (lb_rd),
      .ready   (lb_ready)
   );

   mrfpg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // clamped sizes
   always_comb begin
      cols_eff = cols_ff;
      if (cols_ff < DW'(3)) cols_eff = DW'(3);
      if (cols_ff > DW'(mrfpg_pkg::MAX_COLUMNS)) cols_eff = DW'(mrfpg_pkg::MAX_COLUMNS);
      rows_eff = rows_ff;
      if (rows_ff < DW'(3)) rows_eff = DW'(3);
      if (rows_ff > DW'(mrfpg_pkg::MAX_ROWS)) rows_eff = DW'(mrfpg_pkg::MAX_ROWS);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = !(state_ff == ST_IDLE && lb_ready);
   assign col_nx    = {1'b0, col_ff} + 1'b1;
   assign row_nx    = {1'b0, row_ff} + 1'b1;
   assign above2    = par_ff ? lb_rd[2*PB-1:PB] : lb_rd[PB-1:0];
   assign above1    = par_ff ? lb_rd[PB-1:0] : lb_rd[2*PB-1:PB];
   assign huber_quad = {aa_ff, 16'd0} < {16'd0, dd_ff};
   assign term = neg_ff ? -$signed({4'd0, div_rsp.quotient})
                        : $signed({4'd0, div_rsp.quotient});

   // neighbour picked by term index: straight ones first, then diagonals
   always_comb begin
      unique case (k_ff[2:0])
         3'd0: nb = win_ff[3];
         3'd1: nb = win_ff[5];
         3'd2: nb = win_ff[1];
         3'd3: nb = win_ff[7];
         3'd4: nb = win_ff[0];
         3'd5: nb = win_ff[2];
         3'd6: nb = win_ff[6];
         default: nb = win_ff[8];
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      win_in   = win_ff;
      px_in    = px_ff;
      wcol_in  = wcol_ff;
      par_in   = par_ff;
      emit_in  = emit_ff;
      last_in  = last_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      dqe_in   = dqe_ff;
      dd_in    = dd_ff;
      curv_in  = curv_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      w_in     = w_ff;
      wa_in    = wa_ff;
      aa_in    = aa_ff;
      wad_in   = wad_ff;
      s_in     = s_ff;
      phase_in = phase_ff;
      sum_in   = sum_ff;
      rv_in    = rv_ff && rsp_stall;
      rgrad_in = rgrad_ff;
      rrow_in  = rrow_ff;
      rcol_in  = rcol_ff;
      rcurv_in = rcurv_ff;
      rlast_in = rlast_ff;
      lb_req   = '0;
      div_req  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in   = req_pixel;
               wcol_in = col_ff;
               par_in  = row_ff[0];
               lb_req.rd_en   = 1'b1;
               lb_req.rd_addr = col_ff;
               emit_in = row_ff >= PW'(2) && col_ff >= PW'(2)
                         && {1'b0, row_ff} < rows_eff && {1'b0, col_ff} < cols_eff;
               last_in = {1'b0, row_ff} == rows_eff - 1'b1
                         && {1'b0, col_ff} == cols_eff - 1'b1;
               orow_in = row_ff - 1'b1;
               ocol_in = col_ff - 1'b1;
               dqe_in  = (dq_ff == 16'd0) ? 16'd1 : dq_ff;
               // position of the next pixel
               if (col_nx >= cols_eff) begin
                  col_in = '0;
                  row_in = (row_nx >= rows_eff) ? '0 : row_nx[PW-1:0];
               end else begin
                  col_in = col_nx[PW-1:0];
                  if ({1'b0, row_ff} >= rows_eff) row_in = '0;
               end
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            win_in[0] = win_ff[1]; win_in[1] = win_ff[2]; win_in[2] = above2;
            win_in[3] = win_ff[4]; win_in[4] = win_ff[5]; win_in[5] = above1;
            win_in[6] = win_ff[7]; win_in[7] = win_ff[8]; win_in[8] = px_ff;
            lb_req.wr_en   = 1'b1;
            lb_req.wr_addr = wcol_ff;
            lb_req.wr_data = par_ff ? {px_ff, lb_rd[PB-1:0]} : {lb_rd[2*PB-1:PB], px_ff};
            dd_in    = dqe_ff * dqe_ff;
            // a Geman term of the previous pixel may leave the phase set
            phase_in = 1'b0;
            if (emit_ff) begin
               state_in = ST_CURV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CURV: begin
            // curvature 2^32 / D, started once then awaited
            if (!div_rsp.busy && !div_rsp.done && !phase_ff) begin
               div_req.start = 1'b1;
               div_req.num   = mrfpg_pkg::DIV_NUM_W'(64'h1_0000_0000);
               div_req.den   = mrfpg_pkg::DIV_DEN_W'(dd_ff);
               phase_in      = 1'b1;
            end else if (div_rsp.done) begin
               curv_in  = (div_rsp.quotient[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                             : div_rsp.quotient[31:0];
               phase_in = 1'b0;
               k_in     = '0;
               sum_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (k_ff == (eight_ff ? 4'd8 : 4'd4)) begin
               state_in = ST_OUT;
            end else begin
               a_in   = (nb >= win_ff[4]) ? nb - win_ff[4] : win_ff[4] - nb;
               neg_in = nb < win_ff[4];
               w_in   = k_ff[2] ? mrfpg_pkg::W8_MIXED
                                : (eight_ff ? mrfpg_pkg::W4_MIXED : mrfpg_pkg::W4_ONLY);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            wa_in = w_ff * a_ff;
            aa_in = a_ff * a_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            wad_in = {31'd0, wa_ff} * {30'd0, dd_ff};
            s_in   = {1'b0, aa_ff, 16'd0} + {16'd0, dd_ff, 1'b0};
            state_in = ST_START;
         end
         ST_START: begin
            phase_in = 1'b0;
            // zero difference and unknown potential give no contribution
            if (a_ff == '0 || pot_ff == mrfpg_pkg::POT_UNKNOWN) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_LOAD;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
               if (pot_ff == mrfpg_pkg::POT_GEMAN) begin
                  div_req.num = {1'b0, wad_ff, 18'd0};
                  div_req.den = s_ff;
               end else if (pot_ff == mrfpg_pkg::POT_HUBER && !huber_quad) begin
                  div_req.num = mrfpg_pkg::DIV_NUM_W'({w_ff, 8'd0});
                  div_req.den = mrfpg_pkg::DIV_DEN_W'(dqe_ff);
               end else begin
                  div_req.num = mrfpg_pkg::DIV_NUM_W'({wa_ff, 16'd0});
                  div_req.den = mrfpg_pkg::DIV_DEN_W'(dd_ff);
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (pot_ff == mrfpg_pkg::POT_GEMAN && !phase_ff) begin
                  // second Geman pass divides by S again
                  div_req.start = 1'b1;
                  div_req.num   = mrfpg_pkg::DIV_NUM_W'(div_rsp.quotient);
                  div_req.den   = s_ff;
                  phase_in      = 1'b1;
               end else begin
                  sum_in   = sum_ff + term;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               if (sum_ff > 52'sd2147483647) begin
                  rgrad_in = 32'sh7FFF_FFFF;
               end else if (sum_ff < -52'sd2147483648) begin
                  rgrad_in = 32'sh8000_0000;
               end else begin
                  rgrad_in = sum_ff[31:0];
               end
               rrow_in  = orow_ff;
               rcol_in  = ocol_ff;
               rcurv_in = curv_ff;
               rlast_in = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cols_ff  <= DW'(256);
         rows_ff  <= DW'(256);
         dq_ff    <= 16'd256;
         eight_ff <= 1'b0;
         pot_ff   <= mrfpg_pkg::POT_QUAD;
         col_ff   <= '0;
         row_ff   <= '0;
         rv_ff    <= 1'b0;
         phase_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         rv_ff    <= rv_in;
         phase_ff <= phase_in;
         win_ff   <= win_in;
         if (csr_write) begin
            unique case (csr_index)
               mrfpg_pkg::CSR_COLUMNS:   cols_ff  <= csr_data[DW-1:0];
               mrfpg_pkg::CSR_ROWS:      rows_ff  <= csr_data[DW-1:0];
               mrfpg_pkg::CSR_DELTA:     dq_ff    <= csr_data;
               mrfpg_pkg::CSR_EIGHT:     eight_ff <= csr_data[0];
               mrfpg_pkg::CSR_POTENTIAL: pot_ff   <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      wcol_ff  <= wcol_in;
      par_ff   <= par_in;
      emit_ff  <= emit_in;
      last_ff  <= last_in;
      orow_ff  <= orow_in;
      ocol_ff  <= ocol_in;
      dqe_ff   <= dqe_in;
      dd_ff    <= dd_in;
      curv_ff  <= curv_in;
      k_ff     <= k_in;
      a_ff     <= a_in;
      neg_ff   <= neg_in;
      w_ff     <= w_in;
      wa_ff    <= wa_in;
      aa_ff    <= aa_in;
      wad_ff   <= wad_in;
      s_ff     <= s_in;
      sum_ff   <= sum_in;
      rgrad_ff <= rgrad_in;
      rrow_ff  <= rrow_in;
      rcol_ff  <= rcol_in;
      rcurv_ff <= rcurv_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_gradient   = rgrad_ff;
   assign rsp_centre_row = rrow_ff;
   assign rsp_centre_col = rcol_ff;
   assign rsp_curvature  = rcurv_ff;
   assign rsp_last       = rlast_ff;

endmodule
